FILE: sv/jst_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the JSON stream tokenizer.
// No dependencies; imported by every module of the block.
package jst_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int NSLOT  = 3;

    localparam logic [1:0] ST_TOKEN = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] TT_OBJ  = 3'd0;
    localparam logic [2:0] TT_ARR  = 3'd1;
    localparam logic [2:0] TT_STR  = 3'd2;
    localparam logic [2:0] TT_BOOL = 3'd3;
    localparam logic [2:0] TT_NULL = 3'd4;
    localparam logic [2:0] TT_NUM  = 3'd5;

    localparam logic [3:0] ERR_COLON    = 4'd0;
    localparam logic [3:0] ERR_COMMA    = 4'd1;
    localparam logic [3:0] ERR_OVERFLOW = 4'd2;
    localparam logic [3:0] ERR_MISMATCH = 4'd3;
    localparam logic [3:0] ERR_NO_OPEN  = 4'd4;
    localparam logic [3:0] ERR_STRING   = 4'd5;
    localparam logic [3:0] ERR_NUMBER   = 4'd6;
    localparam logic [3:0] ERR_EARLY    = 4'd7;
    localparam logic [3:0] ERR_TOKENS   = 4'd8;
    localparam logic [3:0] ERR_LONG     = 4'd9;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] token_index;
        logic [2:0]  token_type;
        logic [15:0] start_offset;
        logic [15:0] end_offset;
        logic [11:0] child_count;
        logic [3:0]  error_code;
    } rec_t;

    typedef struct packed {
        logic [1:0]       count;
        rec_t [NSLOT-1:0] recs;
    } bundle_t;

endpackage

FILE: sv/json_stream_tokenizer.sv
`timescale 1ns / 1ps
// JSON stream tokenizer, top level: front end, bundle queue, back end.
// Takes one byte per cycle while the queue is not full; each result is registered
// in the queue, then in the output register; a byte with k results gives k transfers.
// A 4-bundle queue absorbs bursts. One result per cycle while m_tready is high.
// rst_n asynchronously clears control state; stack contents are left undefined.
module json_stream_tokenizer import jst_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_TOKENS  = 4096,
    parameter int MAX_LENGTH  = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // token_index, token_type, start_offset, end_offset,
                                   // child_count, error_code, one zero pad bit
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast    // last_result
);

    logic    q_full, q_empty, q_push, q_pop, accept;
    bundle_t f_bundle, q_head;
    rec_t    o_rec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    jst_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_TOKENS  (MAX_TOKENS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .byte_value (s_tdata),
        .last_byte  (s_tlast),
        .push       (q_push),
        .bundle     (f_bundle)
    );

    jst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (f_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    jst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (o_rec),
        .out_last  (m_tlast)
    );

    assign m_tuser = o_rec.status;
    assign m_tdata = {1'b0, o_rec.error_code, o_rec.child_count, o_rec.end_offset,
                      o_rec.start_offset, o_rec.token_type, o_rec.token_index};

endmodule

FILE: sv/jst_front.sv
`timescale 1ns / 1ps
// Front end: classifies each byte, keeps the container stack and scan mode,
// and produces a bundle of up to three result records. Uses jst_pkg.
module jst_front import jst_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_TOKENS  = 4096,
    parameter int MAX_LENGTH  = 65535
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_value,
    input  logic       last_byte,
    output logic       push,
    output bundle_t    bundle
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TC_W  = $clog2(MAX_TOKENS + 1);
    localparam int POS_W = $clog2(MAX_LENGTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_STR, MODE_ESC, MODE_BOOL, MODE_NULL,
        MODE_NUM0, MODE_NUM1, MODE_NUM2, MODE_NUM3, MODE_NUM4, MODE_NUM5, MODE_NUM6
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [TC_W-1:0]   tc_reg, tc_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  sstart_reg, sstart_next;
    logic [2:0]        prev_reg, prev_next;
    logic              any_reg, any_next;
    logic              errf_reg, errf_next;

    logic [TC_W-1:0]   stk_idx_reg   [STACK_DEPTH];
    logic              stk_kind_reg  [STACK_DEPTH];
    logic [11:0]       stk_child_reg [STACK_DEPTH];
    logic [POS_W-1:0]  stk_start_reg [STACK_DEPTH];

    logic [SP_W-1:0]   sp_top, sp_push;
    logic [11:0]       top_child;
    logic              child_en, push_en, push_kind;

    logic              is_ws, is_sign, is_digit, is_dot, is_e, is_term, in_bool, in_null;

    assign sp_top  = SP_W'(level_reg - 1'b1);
    assign sp_push = SP_W'(level_reg);

    always_comb
    begin
        is_ws    = (byte_value == 8'h09) || (byte_value == 8'h0D) ||
                   (byte_value == 8'h0A) || (byte_value == 8'h20);
        is_sign  = (byte_value == "+") || (byte_value == "-");
        is_digit = (byte_value >= "0") && (byte_value <= "9");
        is_dot   = (byte_value == ".");
        is_e     = (byte_value == "e") || (byte_value == "E");
        is_term  = is_ws || (byte_value == "}") || (byte_value == "]") || (byte_value == ",");
        in_bool  = (byte_value == "t") || (byte_value == "r") || (byte_value == "u") ||
                   (byte_value == "e") || (byte_value == "f") || (byte_value == "a") ||
                   (byte_value == "l") || (byte_value == "s");
        in_null  = (byte_value == "n") || (byte_value == "u") || (byte_value == "l");
    end

    always_comb
    begin
        logic       err;
        logic [3:0] ecode;
        logic [1:0] n;
        logic       consumed;
        logic       found;
        mode_t      nm;
        logic [2:0] q;
        logic       kind;

        mode_next   = mode_reg;
        level_next  = level_reg;
        tc_next     = tc_reg;
        pos_next    = pos_reg;
        sstart_next = sstart_reg;
        prev_next   = prev_reg;
        any_next    = any_reg;
        errf_next   = errf_reg;
        top_child   = stk_child_reg[sp_top];
        child_en    = 1'b0;
        push_en     = 1'b0;
        push_kind   = 1'b0;
        bundle      = '0;
        err         = 1'b0;
        ecode       = ERR_COLON;
        n           = 2'd0;
        consumed    = 1'b0;
        found       = 1'b0;
        nm          = MODE_IDLE;
        q           = 3'd0;
        kind        = 1'b0;

        if (accept)
        begin
            if (!errf_reg)
            begin
                if (pos_reg >= POS_W'(MAX_LENGTH))
                begin
                    err   = 1'b1;
                    ecode = ERR_LONG;
                end
                else
                begin
                    case (mode_reg)
                        MODE_STR:
                        begin
                            consumed = 1'b1;
                            if (byte_value == 8'h5C)
                                mode_next = MODE_ESC;
                            else if (byte_value == 8'h22)
                            begin
                                bundle.recs[n] = '{ST_TOKEN, 12'(tc_next - 1'b1), TT_STR,
                                                   16'(sstart_next), 16'(pos_reg), 12'd0, 4'd0};
                                n = n + 2'd1;
                                if (level_reg != '0)
                                begin
                                    top_child = top_child + 12'd1;
                                    child_en  = 1'b1;
                                end
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_ESC:
                        begin
                            consumed  = 1'b1;
                            mode_next = MODE_STR;
                        end
                        MODE_BOOL, MODE_NULL:
                        begin
                            if ((mode_reg == MODE_BOOL) ? in_bool : in_null)
                                consumed = 1'b1;
                            else
                            begin
                                bundle.recs[n] = '{ST_TOKEN, 12'(tc_next - 1'b1),
                                                   (mode_reg == MODE_BOOL) ? TT_BOOL : TT_NULL,
                                                   16'(sstart_next), 16'(pos_reg), 12'd0, 4'd0};
                                n = n + 2'd1;
                                if (level_reg != '0)
                                begin
                                    top_child = top_child + 12'd1;
                                    child_en  = 1'b1;
                                end
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_NUM0, MODE_NUM1, MODE_NUM2, MODE_NUM3,
                        MODE_NUM4, MODE_NUM5, MODE_NUM6:
                        begin
                            q = 3'(mode_reg - MODE_NUM0);
                            // first phase at or after the current one that takes the byte
                            if (is_sign && q <= 3'd0)      begin found = 1'b1; nm = MODE_NUM0; end
                            else if (is_sign && q <= 3'd5) begin found = 1'b1; nm = MODE_NUM5; end
                            else if (is_digit && q <= 3'd1) begin found = 1'b1; nm = MODE_NUM1; end
                            else if (is_digit && q <= 3'd3) begin found = 1'b1; nm = MODE_NUM3; end
                            else if (is_digit)              begin found = 1'b1; nm = MODE_NUM6; end
                            else if (is_dot && q <= 3'd2)   begin found = 1'b1; nm = MODE_NUM2; end
                            else if (is_e && q <= 3'd4)     begin found = 1'b1; nm = MODE_NUM4; end
                            if (found)
                            begin
                                consumed  = 1'b1;
                                mode_next = nm;
                            end
                            else if (is_term)
                            begin
                                bundle.recs[n] = '{ST_TOKEN, 12'(tc_next - 1'b1), TT_NUM,
                                                   16'(sstart_next), 16'(pos_reg), 12'd0, 4'd0};
                                n = n + 2'd1;
                                if (level_reg != '0)
                                begin
                                    top_child = top_child + 12'd1;
                                    child_en  = 1'b1;
                                end
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                err   = 1'b1;
                                ecode = ERR_NUMBER;
                            end
                        end
                        default: mode_next = MODE_IDLE;
                    endcase

                    if (!consumed && !err)
                    begin
                        if (is_ws)
                        begin
                        end
                        else if (byte_value == ":")
                        begin
                            if (!(any_reg && prev_reg == TT_STR))
                            begin
                                err   = 1'b1;
                                ecode = ERR_COLON;
                            end
                        end
                        else if (byte_value == ",")
                        begin
                            if (level_reg == '0)
                            begin
                                err   = 1'b1;
                                ecode = ERR_COMMA;
                            end
                        end
                        else if (byte_value == "{" || byte_value == "[")
                        begin
                            kind = (byte_value == "[");
                            if (tc_reg >= TC_W'(MAX_TOKENS))
                            begin
                                err   = 1'b1;
                                ecode = ERR_TOKENS;
                            end
                            else if (level_reg >= LVL_W'(STACK_DEPTH))
                            begin
                                err   = 1'b1;
                                ecode = ERR_OVERFLOW;
                            end
                            else
                            begin
                                tc_next   = tc_reg + 1'b1;
                                prev_next = kind ? TT_ARR : TT_OBJ;
                                any_next  = 1'b1;
                                if (level_reg != '0)
                                begin
                                    top_child = top_child + 12'd1;
                                    child_en  = 1'b1;
                                end
                                push_en    = 1'b1;
                                push_kind  = kind;
                                level_next = level_reg + 1'b1;
                            end
                        end
                        else if (byte_value == "}" || byte_value == "]")
                        begin
                            kind = (byte_value == "]");
                            if (level_reg == '0)
                            begin
                                err   = 1'b1;
                                ecode = ERR_NO_OPEN;
                            end
                            else if (stk_kind_reg[sp_top] != kind)
                            begin
                                err   = 1'b1;
                                ecode = ERR_MISMATCH;
                            end
                            else
                            begin
                                level_next = level_reg - 1'b1;
                                bundle.recs[n] = '{ST_TOKEN, 12'(stk_idx_reg[sp_top]),
                                                   kind ? TT_ARR : TT_OBJ,
                                                   16'(stk_start_reg[sp_top]),
                                                   16'(pos_reg + 1'b1), top_child, 4'd0};
                                n = n + 2'd1;
                            end
                        end
                        else if (tc_reg >= TC_W'(MAX_TOKENS))
                        begin
                            err   = 1'b1;
                            ecode = ERR_TOKENS;
                        end
                        else if (byte_value == 8'h22)
                        begin
                            tc_next     = tc_reg + 1'b1;
                            prev_next   = TT_STR;
                            any_next    = 1'b1;
                            sstart_next = pos_reg + 1'b1;
                            mode_next   = MODE_STR;
                        end
                        else if (byte_value == "t" || byte_value == "f" || byte_value == "n")
                        begin
                            tc_next     = tc_reg + 1'b1;
                            prev_next   = (byte_value == "n") ? TT_NULL : TT_BOOL;
                            any_next    = 1'b1;
                            sstart_next = pos_reg;
                            mode_next   = (byte_value == "n") ? MODE_NULL : MODE_BOOL;
                        end
                        else
                        begin
                            tc_next     = tc_reg + 1'b1;
                            prev_next   = TT_NUM;
                            any_next    = 1'b1;
                            sstart_next = pos_reg;
                            if (is_sign)       mode_next = MODE_NUM0;
                            else if (is_digit) mode_next = MODE_NUM1;
                            else if (is_dot)   mode_next = MODE_NUM2;
                            else if (is_e)     mode_next = MODE_NUM4;
                            else
                            begin
                                err   = 1'b1;
                                ecode = ERR_NUMBER;
                            end
                        end
                    end
                    pos_next = pos_reg + 1'b1;
                end

                if (err)
                begin
                    bundle.recs[n] = '{ST_ERROR, 12'd0, 3'd0, 16'd0, 16'd0, 12'd0, ecode};
                    n = n + 2'd1;
                    errf_next = 1'b1;
                end
                else if (last_byte)
                begin
                    if (mode_next == MODE_STR || mode_next == MODE_ESC)
                    begin
                        bundle.recs[n] = '{ST_ERROR, 12'd0, 3'd0, 16'd0, 16'd0, 12'd0,
                                           ERR_STRING};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        if (mode_next != MODE_IDLE)
                        begin
                            bundle.recs[n] = '{ST_TOKEN, 12'(tc_next - 1'b1),
                                               (mode_next == MODE_BOOL) ? TT_BOOL :
                                               (mode_next == MODE_NULL) ? TT_NULL : TT_NUM,
                                               16'(sstart_next), 16'(pos_reg + 1'b1),
                                               12'd0, 4'd0};
                            n = n + 2'd1;
                        end
                        if (level_next != '0)
                            bundle.recs[n] = '{ST_ERROR, 12'd0, 3'd0, 16'd0, 16'd0, 12'd0,
                                               ERR_EARLY};
                        else
                            bundle.recs[n] = '{ST_DONE, 12'd0, 3'd0, 16'd0, 16'd0, 12'd0,
                                               4'd0};
                        n = n + 2'd1;
                    end
                end
            end

            if (last_byte)
            begin
                // per-document state returns to its reset value
                mode_next   = MODE_IDLE;
                level_next  = '0;
                tc_next     = '0;
                pos_next    = '0;
                sstart_next = '0;
                prev_next   = 3'd0;
                any_next    = 1'b0;
                errf_next   = 1'b0;
            end
        end
        bundle.count = n;
    end

    assign push = accept && (bundle.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            level_reg  <= '0;
            tc_reg     <= '0;
            pos_reg    <= '0;
            sstart_reg <= '0;
            prev_reg   <= 3'd0;
            any_reg    <= 1'b0;
            errf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            level_reg  <= level_next;
            tc_reg     <= tc_next;
            pos_reg    <= pos_next;
            sstart_reg <= sstart_next;
            prev_reg   <= prev_next;
            any_reg    <= any_next;
            errf_reg   <= errf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (child_en)
            stk_child_reg[sp_top] <= top_child;
        if (push_en)
        begin
            stk_idx_reg[sp_push]   <= tc_reg;
            stk_kind_reg[sp_push]  <= push_kind;
            stk_child_reg[sp_push] <= 12'd0;
            stk_start_reg[sp_push] <= pos_reg;
        end
    end

endmodule

FILE: sv/jst_queue.sv
`timescale 1ns / 1ps
// Short queue of result bundles between the front and back ends.
// Uses jst_pkg for the bundle type and depth.
module jst_queue import jst_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    empty
);

    bundle_t            q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next;
    logic [QPTR_W-1:0]  rd_reg, rd_next;
    logic [QPTR_W:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = q_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_data;
    end

endmodule

FILE: sv/jst_back.sv
`timescale 1ns / 1ps
// Back end: unpacks queued bundles into one result record per transfer
// through an output register. Uses jst_pkg.
module jst_back import jst_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  bundle_t head,
    input  logic    empty,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output rec_t    out_rec,
    output logic    out_last
);

    logic [1:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    rec_t       rec_reg;
    logic       last_reg;
    logic       load, is_last;

    assign load    = !empty && (!valid_reg || out_ready);
    assign is_last = (sub_reg == head.count - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = is_last ? 2'd0 : sub_reg + 2'd1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg  <= head.recs[sub_reg];
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;
    assign out_last  = last_reg;

endmodule

FILE: sv/jst_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the JSON stream tokenizer, bound to the top level.
// Depends on json_stream_tokenizer ports and the status codes in jst_pkg.
module jst_checker import jst_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_TOKEN || m_tuser == ST_DONE || m_tuser == ST_ERROR))
        else $error("illegal status code");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_TOKEN) |-> m_tlast)
        else $error("done or error result not marked last");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_DONE) |-> (m_tdata == 64'd0))
        else $error("done result carries data");

    a_token_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_TOKEN) |-> (m_tdata[62:59] == 4'd0 && m_tdata[14:12] <= 3'd5))
        else $error("token record with error code or bad type");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind json_stream_tokenizer jst_checker u_jst_checker (.*);
